// File: rtl/ace_pkg.sv
`timescale 1ns / 1ps

package ace_pkg;

	localparam int GLYPH_W   = 8;
	localparam int COLOR_W   = 7;
	localparam int LEN_W     = 9;
	localparam int CFG_IDX_W = 1;
	localparam int RUN_MAX   = 13;
	localparam int RUN_LEN_W = 4;

	localparam int MAX_COLUMNS_DEF = 256;
	localparam int MAX_ROWS_DEF    = 256;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 1'b1;

	localparam logic [LEN_W-1:0] ROW_LENGTH_RST = 9'd80;
	localparam logic [LEN_W-1:0] ROW_COUNT_RST  = 9'd24;

	localparam logic [COLOR_W-1:0] COLOR_MAX = 7'd99;

	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_FOUR     = 8'h34;
	localparam logic [7:0] CH_M        = 8'h6D;
	localparam logic [7:0] CH_H        = 8'h48;
	localparam logic [7:0] CH_NL       = 8'h0A;
	localparam logic [7:0] CH_ZERO     = 8'h30;

	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [RUN_LEN_W-1:0]    len;
		logic                    frame_end;
	} run_t;

	// tens digit of a value below 100 via reciprocal multiply
	function automatic logic [3:0] tens_digit(input logic [COLOR_W-1:0] c);
		logic [17:0] p;
		p = 18'(c) * 18'd205;
		return p[14:11];
	endfunction

	function automatic logic [7:0] tens_char(input logic [COLOR_W-1:0] c);
		return CH_ZERO + {4'h0, tens_digit(c)};
	endfunction

	function automatic logic [7:0] ones_char(input logic [COLOR_W-1:0] c);
		logic [COLOR_W-1:0] t10;
		logic [COLOR_W-1:0] r;
		t10 = COLOR_W'({3'b000, tens_digit(c)} * 7'd10);
		r = c - t10;
		return CH_ZERO + {1'b0, r};
	endfunction

endpackage

// File: rtl/ace_encode.sv
`timescale 1ns / 1ps

module ace_encode #(
	parameter int MAX_COLUMNS = ace_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = ace_pkg::MAX_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [ace_pkg::GLYPH_W-1:0]   glyph_s1,
	input  logic [ace_pkg::COLOR_W-1:0]   fg_s1,
	input  logic [ace_pkg::COLOR_W-1:0]   bg_s1,
	input  logic [ace_pkg::LEN_W-1:0]     row_length_q,
	input  logic [ace_pkg::LEN_W-1:0]     row_count_q,
	output ace_pkg::run_t                 run
);

	localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CLW   = $clog2(MAX_COLUMNS + 1);
	localparam int RLW   = $clog2(MAX_ROWS + 1);
	localparam int CCMPW = ((CLW > ace_pkg::LEN_W) ? CLW : ace_pkg::LEN_W) + 1;
	localparam int RCMPW = ((RLW > ace_pkg::LEN_W) ? RLW : ace_pkg::LEN_W) + 1;

	logic [CW-1:0]                 column_pos_q;
	logic [RW-1:0]                 row_pos_q;
	logic [ace_pkg::COLOR_W-1:0]   current_fg_q;
	logic [ace_pkg::COLOR_W-1:0]   current_bg_q;
	logic                          fg_known_q;
	logic                          bg_known_q;

	logic [ace_pkg::COLOR_W-1:0]   fg;
	logic [ace_pkg::COLOR_W-1:0]   bg;
	logic [ace_pkg::COLOR_W-1:0]   one_color;
	logic [CCMPW-1:0]              len_ext;
	logic [CCMPW-1:0]              cols;
	logic [RCMPW-1:0]              cnt_ext;
	logic [RCMPW-1:0]              rows;
	logic                          row_start;
	logic                          home;
	logic                          row_end;
	logic                          last_row;
	logic                          fg_diff;
	logic                          bg_diff;
	logic                          newline;
	logic [ace_pkg::RUN_LEN_W-1:0] hlen;
	logic [ace_pkg::RUN_LEN_W-1:0] clen;
	logic [ace_pkg::RUN_LEN_W-1:0] gpos;
	logic [ace_pkg::RUN_LEN_W-1:0] cidx;
	logic [7:0][7:0]               col_bytes;

	assign fg = (fg_s1 > ace_pkg::COLOR_MAX) ? ace_pkg::COLOR_MAX : fg_s1;
	assign bg = (bg_s1 > ace_pkg::COLOR_MAX) ? ace_pkg::COLOR_MAX : bg_s1;

	// clamp lengths to 1..max
	assign len_ext = CCMPW'(row_length_q);
	assign cols    = (len_ext == '0) ? CCMPW'(1) :
		(len_ext > CCMPW'(MAX_COLUMNS)) ? CCMPW'(MAX_COLUMNS) : len_ext;
	assign cnt_ext = RCMPW'(row_count_q);
	assign rows    = (cnt_ext == '0) ? RCMPW'(1) :
		(cnt_ext > RCMPW'(MAX_ROWS)) ? RCMPW'(MAX_ROWS) : cnt_ext;

	assign row_start = (column_pos_q == '0);
	assign home      = row_start && (row_pos_q == '0);
	assign row_end   = (CCMPW'(column_pos_q) + CCMPW'(1)) >= cols;
	assign last_row  = (RCMPW'(row_pos_q) + RCMPW'(1)) >= rows;
	assign newline   = row_end && !last_row;

	// colour tracking is forgotten at each row start
	assign fg_diff   = row_start || !fg_known_q || (current_fg_q != fg);
	assign bg_diff   = row_start || !bg_known_q || (current_bg_q != bg);
	assign one_color = fg_diff ? fg : bg;

	assign hlen = home ? 4'd3 : 4'd0;
	assign clen = (fg_diff && bg_diff) ? 4'd8 : (fg_diff || bg_diff) ? 4'd5 : 4'd0;
	assign gpos = hlen + clen;

	always_comb begin
		if (fg_diff && bg_diff) begin
			col_bytes[0] = ace_pkg::CH_ESC;
			col_bytes[1] = ace_pkg::CH_LBRACKET;
			col_bytes[2] = ace_pkg::tens_char(fg);
			col_bytes[3] = ace_pkg::ones_char(fg);
			col_bytes[4] = ace_pkg::CH_SEMI;
			col_bytes[5] = ace_pkg::CH_FOUR;
			col_bytes[6] = ace_pkg::ones_char(bg);
			col_bytes[7] = ace_pkg::CH_M;
		end else begin
			col_bytes[0] = ace_pkg::CH_ESC;
			col_bytes[1] = ace_pkg::CH_LBRACKET;
			col_bytes[2] = ace_pkg::tens_char(one_color);
			col_bytes[3] = ace_pkg::ones_char(one_color);
			col_bytes[4] = ace_pkg::CH_M;
			col_bytes[5] = ace_pkg::CH_M;
			col_bytes[6] = ace_pkg::CH_M;
			col_bytes[7] = ace_pkg::CH_M;
		end
	end

	always_comb begin
		cidx = '0;
		for (int p = 0; p < ace_pkg::RUN_MAX; p++) begin
			cidx = ace_pkg::RUN_LEN_W'(p) - hlen;
			if (ace_pkg::RUN_LEN_W'(p) < hlen) begin
				run.bytes[p] = (p == 0) ? ace_pkg::CH_ESC :
					(p == 1) ? ace_pkg::CH_LBRACKET : ace_pkg::CH_H;
			end else if (ace_pkg::RUN_LEN_W'(p) < gpos) begin
				run.bytes[p] = col_bytes[cidx[2:0]];
			end else if (ace_pkg::RUN_LEN_W'(p) == gpos) begin
				run.bytes[p] = glyph_s1;
			end else begin
				run.bytes[p] = ace_pkg::CH_NL;
			end
		end
		run.len       = gpos + 4'd1 + {3'b000, newline};
		run.frame_end = row_end && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_pos_q <= '0;
			row_pos_q    <= '0;
			current_fg_q <= '0;
			current_bg_q <= '0;
			fg_known_q   <= 1'b0;
			bg_known_q   <= 1'b0;
		end else if (take) begin
			current_fg_q <= fg;
			current_bg_q <= bg;
			fg_known_q   <= 1'b1;
			bg_known_q   <= 1'b1;
			if (row_end) begin
				column_pos_q <= '0;
				if (last_row) begin
					row_pos_q <= '0;
				end else begin
					row_pos_q <= row_pos_q + RW'(1);
				end
			end else begin
				column_pos_q <= column_pos_q + CW'(1);
			end
		end
	end

endmodule

// File: rtl/ace_serializer.sv
`timescale 1ns / 1ps

module ace_serializer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  ace_pkg::run_t run,
	input  logic          out_stall,
	output logic          free,
	output logic          out_valid,
	output logic [7:0]    out_byte,
	output logic          last_of_run,
	output logic          frame_done
);

	logic [ace_pkg::RUN_MAX-1:0][7:0] bytes_s2;
	logic [ace_pkg::RUN_LEN_W-1:0]    cnt_s2;
	logic                             frame_s2;
	logic                             pop;

	assign out_valid   = (cnt_s2 != '0);
	assign out_byte    = bytes_s2[0];
	assign last_of_run = (cnt_s2 == ace_pkg::RUN_LEN_W'(1));
	assign frame_done  = last_of_run && frame_s2;
	assign pop         = out_valid && !out_stall;
	assign free        = !out_valid || (pop && last_of_run);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (load) begin
			cnt_s2 <= run.len;
		end else if (pop) begin
			cnt_s2 <= cnt_s2 - ace_pkg::RUN_LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= run.bytes;
			frame_s2 <= run.frame_end;
		end else if (pop) begin
			bytes_s2 <= {8'h00, bytes_s2[ace_pkg::RUN_MAX-1:1]};
		end
	end

endmodule

// File: rtl/ansi_cell_stream_encoder_top.sv
`timescale 1ns / 1ps
// channel   direction   handshake                payload
// in        input       in_valid / in_stall      glyph, fg_color, back_color
// out       output      out_valid / out_stall    out_byte, last_of_run, frame_done
// cfg       input       cfg_wr_en                cfg_index, cfg_data
//
// a cell yields 1 to 13 bytes, one per cycle while out_stall is low; the next cell
// waits encoded in the input register and its run follows the last byte of the
// current run with no gap
// accepted cells go to the input register, then their runs load to the serializer
// reset: row_length 80, row_count 24, position at frame home, colours unknown
// out_stall freezes the current byte; in_stall is high while a cell waits in the
// input register behind a run whose last byte does not leave in that cycle

module ansi_cell_stream_encoder_top #(
	parameter int MAX_COLUMNS = ace_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = ace_pkg::MAX_ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ace_pkg::GLYPH_W-1:0]     glyph,
	input  logic [ace_pkg::COLOR_W-1:0]     fg_color,
	input  logic [ace_pkg::COLOR_W-1:0]     back_color,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      out_byte,
	output logic                            last_of_run,
	output logic                            frame_done,
	input  logic                            cfg_wr_en,
	input  logic [ace_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ace_pkg::LEN_W-1:0]       cfg_data
);

	logic [ace_pkg::LEN_W-1:0]   row_length_q;
	logic [ace_pkg::LEN_W-1:0]   row_count_q;
	logic                        valid_s1;
	logic [ace_pkg::GLYPH_W-1:0] glyph_s1;
	logic [ace_pkg::COLOR_W-1:0] fg_s1;
	logic [ace_pkg::COLOR_W-1:0] bg_s1;
	logic                        free;
	logic                        load;
	logic                        accept;
	ace_pkg::run_t               run;

	assign load     = valid_s1 && free;
	assign in_stall = valid_s1 && !free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ace_pkg::ROW_LENGTH_RST;
			row_count_q  <= ace_pkg::ROW_COUNT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ace_pkg::REG_ROW_LENGTH: row_length_q <= cfg_data;
				ace_pkg::REG_ROW_COUNT:  row_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			glyph_s1 <= glyph;
			fg_s1    <= fg_color;
			bg_s1    <= back_color;
		end
	end

	ace_encode #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) u_encode (
		.clk(clk),
		.arst_n(arst_n),
		.take(load),
		.glyph_s1(glyph_s1),
		.fg_s1(fg_s1),
		.bg_s1(bg_s1),
		.row_length_q(row_length_q),
		.row_count_q(row_count_q),
		.run(run)
	);

	ace_serializer u_serializer (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.run(run),
		.out_stall(out_stall),
		.free(free),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.last_of_run(last_of_run),
		.frame_done(frame_done)
	);

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_of_run) |=> out_valid)
		else $error("byte run ended before its last byte");

	a_frame_on_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done) |-> last_of_run)
		else $error("frame end flagged inside a run");

	a_load_min_len: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("encoded run produced no byte");

endmodule

// File: dv/tb_ansi_cell_stream_encoder_top.sv
`timescale 1ns / 1ps

module tb_ansi_cell_stream_encoder_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int N_PHASES    = 10;
	localparam int PHASE_CELLS = 50;
	localparam int RUN_BITS    = ace_pkg::RUN_MAX * 8;

	typedef enum {STEP_CELL, STEP_CFG} step_kind_t;

	typedef struct {
		step_kind_t                        kind;
		bit [ace_pkg::GLYPH_W-1:0]         glyph;
		bit [ace_pkg::COLOR_W-1:0]         fg;
		bit [ace_pkg::COLOR_W-1:0]         bg;
		bit [ace_pkg::CFG_IDX_W-1:0]       idx;
		bit [ace_pkg::LEN_W-1:0]           val;
		int                                n_typed;
		bit [ace_pkg::RUN_MAX-1:0][7:0]    typed;
		bit                                typed_frame;
	} step_t;

	typedef struct {
		bit [7:0] b;
		bit       last;
		bit       fdone;
	} stream_byte_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [ace_pkg::GLYPH_W-1:0]   glyph;
	logic [ace_pkg::COLOR_W-1:0]   fg_color;
	logic [ace_pkg::COLOR_W-1:0]   back_color;
	logic                          out_valid;
	logic                          out_stall;
	logic [7:0]                    out_byte;
	logic                          last_of_run;
	logic                          frame_done;
	logic                          cfg_wr_en;
	logic [ace_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ace_pkg::LEN_W-1:0]     cfg_data;

	// encoder state as the testbench sees it
	bit [ace_pkg::LEN_W-1:0]   len_reg;
	bit [ace_pkg::LEN_W-1:0]   cnt_reg;
	int                        col_at;
	int                        row_at;
	bit [ace_pkg::COLOR_W-1:0] fg_now;
	bit [ace_pkg::COLOR_W-1:0] bg_now;
	bit                        fg_valid;
	bit                        bg_valid;

	bit [7:0]     run_bytes[$];
	bit           run_frame_end;
	stream_byte_t pending_bytes[$];

	int mismatches;
	int cycle_cnt;
	int gap_pct;
	int stall_pct;

	ansi_cell_stream_encoder_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.glyph       (glyph),
		.fg_color    (fg_color),
		.back_color  (back_color),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.frame_done  (frame_done),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic bit [ace_pkg::COLOR_W-1:0] sat_color(bit [ace_pkg::COLOR_W-1:0] c);
		return (c > ace_pkg::COLOR_MAX) ? ace_pkg::COLOR_MAX : c;
	endfunction

	function automatic int eff_len(bit [ace_pkg::LEN_W-1:0] v, int lim);
		if (v == 0)
			return 1;
		return (v > lim) ? lim : int'(v);
	endfunction

	// byte run that one cell produces; advances the tracked state
	function automatic void encode_cell(bit [7:0] g, bit [ace_pkg::COLOR_W-1:0] f_raw,
			bit [ace_pkg::COLOR_W-1:0] b_raw);
		bit [ace_pkg::COLOR_W-1:0] f;
		bit [ace_pkg::COLOR_W-1:0] b;
		bit [ace_pkg::COLOR_W-1:0] c;
		int cols;
		int rows;
		bit row_end;
		bit last_row;
		bit fd;
		bit bd;
		f = sat_color(f_raw);
		b = sat_color(b_raw);
		cols = eff_len(len_reg, ace_pkg::MAX_COLUMNS_DEF);
		rows = eff_len(cnt_reg, ace_pkg::MAX_ROWS_DEF);
		row_end = col_at + 1 >= cols;
		last_row = row_at + 1 >= rows;
		run_bytes.delete();
		run_frame_end = 1'b0;
		if (col_at == 0) begin
			fg_valid = 1'b0;
			bg_valid = 1'b0;
			if (row_at == 0) begin
				run_bytes.push_back(ace_pkg::CH_ESC);
				run_bytes.push_back(ace_pkg::CH_LBRACKET);
				run_bytes.push_back(ace_pkg::CH_H);
			end
		end
		fd = !fg_valid || fg_now != f;
		bd = !bg_valid || bg_now != b;
		if (fd && bd) begin
			run_bytes.push_back(ace_pkg::CH_ESC);
			run_bytes.push_back(ace_pkg::CH_LBRACKET);
			run_bytes.push_back(8'(ace_pkg::CH_ZERO + f / 10));
			run_bytes.push_back(8'(ace_pkg::CH_ZERO + f % 10));
			run_bytes.push_back(ace_pkg::CH_SEMI);
			run_bytes.push_back(ace_pkg::CH_FOUR);
			run_bytes.push_back(8'(ace_pkg::CH_ZERO + b % 10));
			run_bytes.push_back(ace_pkg::CH_M);
		end else if (fd || bd) begin
			c = fd ? f : b;
			run_bytes.push_back(ace_pkg::CH_ESC);
			run_bytes.push_back(ace_pkg::CH_LBRACKET);
			run_bytes.push_back(8'(ace_pkg::CH_ZERO + c / 10));
			run_bytes.push_back(8'(ace_pkg::CH_ZERO + c % 10));
			run_bytes.push_back(ace_pkg::CH_M);
		end
		fg_now = f;
		bg_now = b;
		fg_valid = 1'b1;
		bg_valid = 1'b1;
		run_bytes.push_back(g);
		if (row_end) begin
			col_at = 0;
			if (last_row) begin
				row_at = 0;
				run_frame_end = 1'b1;
			end else begin
				run_bytes.push_back(ace_pkg::CH_NL);
				row_at++;
			end
		end else begin
			col_at++;
		end
	endfunction

	function automatic bit [ace_pkg::COLOR_W-1:0] pick_color(bit [ace_pkg::COLOR_W-1:0] prev);
		bit [ace_pkg::COLOR_W-1:0] palette[7] = '{7'd0, 7'd1, 7'd9, 7'd10, 7'd42, 7'd90,
			7'd99};
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return prev;
		if (r < 75)
			return palette[$urandom_range(0, 6)];
		if (r < 90)
			return ace_pkg::COLOR_W'($urandom_range(0, 99));
		return ace_pkg::COLOR_W'($urandom_range(100, 127));
	endfunction

	function automatic step_t cell_step(bit [7:0] g, bit [ace_pkg::COLOR_W-1:0] f,
			bit [ace_pkg::COLOR_W-1:0] b, int n, bit [ace_pkg::RUN_MAX-1:0][7:0] bytes,
			bit fr);
		step_t s;
		s = '{kind: STEP_CELL, glyph: g, fg: f, bg: b, idx: '0, val: '0,
			n_typed: n, typed: bytes, typed_frame: fr};
		return s;
	endfunction

	function automatic step_t cfg_step(bit [ace_pkg::CFG_IDX_W-1:0] i,
			bit [ace_pkg::LEN_W-1:0] v);
		step_t s;
		s = '{kind: STEP_CFG, glyph: '0, fg: '0, bg: '0, idx: i, val: v,
			n_typed: 0, typed: '0, typed_frame: 1'b0};
		return s;
	endfunction

	function automatic void report(string what, int want, int got);
		$display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
		mismatches++;
	endfunction

	// drive one cell and queue its run once it is taken
	task automatic send_cell(bit [7:0] g, bit [ace_pkg::COLOR_W-1:0] f,
			bit [ace_pkg::COLOR_W-1:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		glyph = g;
		fg_color = f;
		back_color = b;
		do
			@(posedge clk);
		while (in_stall);
		foreach (run_bytes[k])
			pending_bytes.push_back('{run_bytes[k], k == run_bytes.size() - 1,
				run_frame_end && k == run_bytes.size() - 1});
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_bytes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(bit [ace_pkg::CFG_IDX_W-1:0] i, bit [ace_pkg::LEN_W-1:0] v);
		cfg_wr_en = 1'b1;
		cfg_index = i;
		cfg_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (i == ace_pkg::REG_ROW_LENGTH)
			len_reg = v;
		else
			cnt_reg = v;
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		stream_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bytes.size() == 0) begin
				report("unexpected out_byte", 0, out_byte);
			end else begin
				want = pending_bytes.pop_front();
				if (out_byte !== want.b)
					report("out_byte", want.b, out_byte);
				if (last_of_run !== want.last)
					report("last_of_run", want.last, last_of_run);
				if (frame_done !== want.fdone)
					report("frame_done", want.fdone, frame_done);
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		step_t                     dir_steps[$];
		bit [ace_pkg::COLOR_W-1:0] rf;
		bit [ace_pkg::COLOR_W-1:0] rb;
		bit [7:0]                  rg;
		int                        len_pick;
		int                        cnt_pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		glyph = '0;
		fg_color = '0;
		back_color = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		gap_pct = 28;
		stall_pct = 28;
		mismatches = 0;
		len_reg = ace_pkg::ROW_LENGTH_RST;
		cnt_reg = ace_pkg::ROW_COUNT_RST;
		col_at = 0;
		row_at = 0;
		fg_now = '0;
		bg_now = '0;
		fg_valid = 1'b0;
		bg_valid = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		dir_steps = '{
			// home plus both colours, saturated
			cell_step(8'hFF, 7'd127, 7'd127, 12,
				RUN_BITS'({ace_pkg::CH_ESC, "[H", ace_pkg::CH_ESC, "[99;49m", 8'hFF}), 1'b0),
			cell_step(8'h00, 7'd99, 7'd99, 1, RUN_BITS'({8'h00}), 1'b0),
			cell_step("A", 7'd0, 7'd127, 6, RUN_BITS'({ace_pkg::CH_ESC, "[00mA"}), 1'b0),
			cell_step("B", 7'd0, 7'd5, 6, RUN_BITS'({ace_pkg::CH_ESC, "[05mB"}), 1'b0),
			// zero length while mid-row ends the row here
			cfg_step(ace_pkg::REG_ROW_LENGTH, 9'd0),
			cell_step("C", 7'd0, 7'd5, 2, RUN_BITS'({"C", ace_pkg::CH_NL}), 1'b0),
			cfg_step(ace_pkg::REG_ROW_COUNT, 9'd0),
			cell_step(8'h7F, 7'd55, 7'd100, 9,
				RUN_BITS'({ace_pkg::CH_ESC, "[55;49m", 8'h7F}), 1'b1),
			cell_step(8'h80, 7'd100, 7'd0, 0, '0, 1'b0),
			cfg_step(ace_pkg::REG_ROW_LENGTH, 9'd511),
			cfg_step(ace_pkg::REG_ROW_COUNT, 9'd257),
			cell_step(8'h20, 7'd3, 7'd4, 0, '0, 1'b0),
			cell_step(8'h21, 7'd3, 7'd4, 0, '0, 1'b0),
			cell_step(8'h22, 7'd3, 7'd40, 0, '0, 1'b0),
			cell_step(8'h23, 7'd9, 7'd40, 0, '0, 1'b0),
			cell_step(8'h24, 7'd90, 7'd19, 0, '0, 1'b0),
			cell_step(8'h55, 7'd10, 7'd64, 0, '0, 1'b0),
			cell_step(8'hAA, 7'd64, 7'd10, 0, '0, 1'b0),
			cell_step(ace_pkg::CH_ESC, 7'd64, 7'd10, 0, '0, 1'b0),
			cfg_step(ace_pkg::REG_ROW_LENGTH, 9'd2),
			cfg_step(ace_pkg::REG_ROW_COUNT, 9'd2),
			cell_step(8'h31, 7'd1, 7'd2, 0, '0, 1'b0),
			cell_step(8'h32, 7'd1, 7'd2, 0, '0, 1'b0),
			cell_step(8'h33, 7'd2, 7'd2, 0, '0, 1'b0),
			cell_step(8'h34, 7'd2, 7'd1, 0, '0, 1'b0),
			cell_step(8'h35, 7'd7, 7'd7, 0, '0, 1'b0)
		};

		foreach (dir_steps[i]) begin
			if (dir_steps[i].kind == STEP_CFG) begin
				wait_idle();
				cfg_write(dir_steps[i].idx, dir_steps[i].val);
			end else begin
				encode_cell(dir_steps[i].glyph, dir_steps[i].fg, dir_steps[i].bg);
				if (dir_steps[i].n_typed != 0) begin
					run_bytes.delete();
					for (int k = dir_steps[i].n_typed - 1; k >= 0; k--)
						run_bytes.push_back(dir_steps[i].typed[k]);
					run_frame_end = dir_steps[i].typed_frame;
				end
				send_cell(dir_steps[i].glyph, dir_steps[i].fg, dir_steps[i].bg);
			end
		end

		rf = '0;
		rb = '0;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin len_pick = 3;   cnt_pick = 2;   end
				1: begin len_pick = 1;   cnt_pick = 1;   end
				2: begin len_pick = 0;   cnt_pick = 0;   end
				3: begin len_pick = 256; cnt_pick = 256; end
				4: begin len_pick = 511; cnt_pick = 300; end
				5: begin len_pick = 4;   cnt_pick = 3;   end
				6: begin len_pick = 2;   cnt_pick = 256; end
				default: begin
					len_pick = $urandom_range(0, 8);
					cnt_pick = $urandom_range(0, 4);
					if ($urandom_range(0, 3) == 0)
						len_pick = $urandom_range(0, 511);
				end
			endcase
			wait_idle();
			cfg_write(ace_pkg::REG_ROW_LENGTH, ace_pkg::LEN_W'(len_pick));
			cfg_write(ace_pkg::REG_ROW_COUNT, ace_pkg::LEN_W'(cnt_pick));
			// no idling on either side in this phase
			gap_pct = (ph == 5) ? 0 : 28;
			stall_pct = (ph == 5) ? 0 : 28;
			for (int n = 0; n < PHASE_CELLS; n++) begin
				rf = pick_color(rf);
				rb = pick_color(rb);
				rg = 8'($urandom_range(0, 255));
				encode_cell(rg, rf, rb);
				send_cell(rg, rf, rb);
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_bytes.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
